// ===== design/bpfa_pkg.sv =====
// Package for the bitmap page frame allocator: request kinds, status codes,
// sequencer states and the control/result bundles of the shared word unit.
// No dependencies.
`timescale 1ns / 1ps

package bpfa_pkg;

   // Bits per bitmap word and the width of a bit index inside a word
   localparam int WORD_BITS = 32;
   localparam int BIT_IDX_W = 5;

   // Request kind, carried on req_tuser
   typedef enum logic [1:0] {
      KIND_ALLOC         = 2'd0,
      KIND_FREE_PAGE     = 2'd1,
      KIND_FREE_RANGE    = 2'd2,
      KIND_RESERVE_RANGE = 2'd3
   } kind_type;

   // Response status, carried on rsp_tuser
   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NO_FRAME = 2'd1,
      STATUS_REJECTED = 2'd2
   } status_type;

   // Operation of the shared word unit
   typedef enum logic [1:0] {
      WOP_SCAN  = 2'd0,
      WOP_CLEAR = 2'd1,
      WOP_SET   = 2'd2
   } word_op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_INIT = 3'd0,
      ST_IDLE = 3'd1,
      ST_PREP = 3'd2,
      ST_WORK = 3'd3,
      ST_RESP = 3'd4
   } state_type;

   // Word unit control: operation and the inclusive bit span to touch
   typedef struct packed {
      word_op_type          op;
      logic [BIT_IDX_W-1:0] lo_bit;
      logic [BIT_IDX_W-1:0] hi_bit;
   } word_ctl_type;

   // Word unit result: updated word and the lowest clear bit
   typedef struct packed {
      logic [WORD_BITS-1:0] new_word;
      logic [BIT_IDX_W-1:0] zero_idx;
      logic                 has_zero;
   } word_res_type;

endpackage

// ===== design/bpfa_word_unit.sv =====
// Shared bitmap word unit: finds the lowest clear bit of a word and applies
// a set, clear or claim-lowest update. Depends on bpfa_pkg.
`timescale 1ns / 1ps

module bpfa_word_unit (
   input  logic [bpfa_pkg::WORD_BITS-1:0] word,
   input  bpfa_pkg::word_ctl_type         ctl,
   output bpfa_pkg::word_res_type         res
);

   logic [bpfa_pkg::WORD_BITS-1:0] low_zero;
   logic [bpfa_pkg::WORD_BITS-1:0] span_mask;
   logic [bpfa_pkg::BIT_IDX_W-1:0] idx;

   // Isolate the lowest clear bit: ~w & (w + 1) is one-hot or zero
   assign low_zero = ~word & (word + bpfa_pkg::WORD_BITS'(1));

   // Encode the one-hot position, each index bit independently
   always_comb begin
      idx = '0;
      for (int k = 0; k < bpfa_pkg::BIT_IDX_W; k++) begin
         for (int b = 0; b < bpfa_pkg::WORD_BITS; b++) begin
            if (((b >> k) & 1) == 1) begin
               idx[k] = idx[k] | low_zero[b];
            end
         end
      end
   end

   // Bits lo_bit..hi_bit inclusive
   assign span_mask = ({bpfa_pkg::WORD_BITS{1'b1}} << ctl.lo_bit)
                    & ({bpfa_pkg::WORD_BITS{1'b1}} >> (5'd31 - ctl.hi_bit));

   // Apply the update
   always_comb begin
      res.zero_idx = idx;
      res.has_zero = |low_zero;
      case (ctl.op)
         bpfa_pkg::WOP_SCAN:  res.new_word = word | low_zero;
         bpfa_pkg::WOP_CLEAR: res.new_word = word & ~span_mask;
         bpfa_pkg::WOP_SET:   res.new_word = word | span_mask;
         default:             res.new_word = word;
      endcase
   end

endmodule

// ===== design/bitmap_page_frame_allocator_top.sv =====
// Bitmap physical page frame allocator, top level.
// Holds the frame bitmap memory and the sequencer; uses bpfa_pkg and bpfa_word_unit.
`timescale 1ns / 1ps

// One used bit per page frame, 32 frames per word in an on-chip memory of
// ceil(NUM_FRAMES/32) words. After reset a clearing pass writes every word to
// all ones (every frame used), one word per cycle, so requests are taken only
// once that pass ends. One request at a time: req_tready is high only while
// idle. Each request passes the setup states IDLE (capture the beat) and PREP
// (work out the frame span), then the memory streams one word per cycle
// through the shared word unit (read one word while writing back the one
// before), then RESP posts the beat once the output register is free.
// Allocate scans from word 0 and stops at the first word with a clear bit.
// Free page touches one word; free and reserve range touch every word of the
// span. Rejected or empty requests skip the word pass.
// The result sits in an output register, so a new request may be taken while
// it waits. PAGE_BYTES must be a power of two.
module bitmap_page_frame_allocator_top #(
   parameter int NUM_FRAMES = 1024,
   parameter int PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] byte_address, [63:32] range_length
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] page_address
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int W   = (NUM_FRAMES + 31) / 32;
   localparam int WAW = (W > 1) ? $clog2(W) : 1;
   localparam int WCW = $clog2(W + 1);
   localparam int FW  = $clog2(NUM_FRAMES + 1);
   localparam int SH  = $clog2(PAGE_BYTES);
   localparam int SW  = 32 - SH;
   localparam int EW  = 33 - SH;

   localparam logic [WCW-1:0] LAST_WORD = WCW'(W - 1);
   localparam logic [FW-1:0]  NF_F      = FW'(NUM_FRAMES);
   localparam logic [EW-1:0]  NF_E      = EW'(NUM_FRAMES);
   localparam logic [FW-1:0]  LAST_FRM  = FW'(NUM_FRAMES - 1);

   // Bitmap memory
   logic [31:0] mem [W];
   logic [31:0] mem_rdata_ff;
   logic        mem_rd_en;
   logic [WAW-1:0] mem_rd_addr;
   logic        mem_wr_en;
   logic [WAW-1:0] mem_wr_addr;
   logic [31:0] mem_wr_data;

   // Sequencer and datapath registers
   bpfa_pkg::state_type   state_ff, state_in;
   bpfa_pkg::kind_type    kind_ff, kind_in;
   bpfa_pkg::word_op_type op_ff, op_in;
   logic [31:0]   addr_ff, addr_in;
   logic [32:0]   sum_ff, sum_in;
   logic [FW-1:0] first_ff, first_in;
   logic [FW-1:0] lastm1_ff, lastm1_in;
   logic [WCW-1:0] rd_cnt_ff, rd_cnt_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [WAW-1:0] rd_idx_ff, rd_idx_in;
   logic [31:0]   res_addr_ff, res_addr_in;
   bpfa_pkg::status_type res_status_ff, res_status_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]    rsp_tuser_ff, rsp_tuser_in;

   // Decode
   logic [SW-1:0]  start_frm;
   logic [EW-1:0]  end_frm;
   logic [EW-1:0]  last_clip;
   logic           free_bad;
   logic           range_empty;
   logic [WAW-1:0] first_w;
   logic [WAW-1:0] last_w;
   logic [FW-1:0]  scan_frame;
   logic           scan_hit;
   logic           scan_fail;
   logic           work_done;
   logic           issue;
   logic           slot_free;

   bpfa_pkg::word_ctl_type wctl;
   bpfa_pkg::word_res_type wres;

   bpfa_word_unit u_word_unit (
      .word (mem_rdata_ff),
      .ctl  (wctl),
      .res  (wres)
   );

   // Request decode and word-pass conditions
   always_comb begin
      start_frm   = addr_ff[31:SH];
      end_frm     = sum_ff[32:SH];
      last_clip   = (end_frm > NF_E) ? NF_E : end_frm;
      free_bad    = (addr_ff == 32'd0) || (addr_ff[SH-1:0] != '0)
                 || (EW'(start_frm) >= NF_E);
      range_empty = (EW'(start_frm) >= last_clip);
      first_w     = WAW'(first_ff >> 5);
      last_w      = WAW'(lastm1_ff >> 5);
      scan_frame  = FW'({rd_idx_ff, wres.zero_idx});
      scan_hit    = rd_vld_ff && wres.has_zero && (scan_frame < NF_F);
      scan_fail   = rd_vld_ff && (wres.has_zero ? (scan_frame >= NF_F)
                                                : (rd_idx_ff == last_w));
      if (op_ff == bpfa_pkg::WOP_SCAN) begin
         work_done = scan_hit || scan_fail;
      end else begin
         work_done = rd_vld_ff && (rd_idx_ff == last_w);
      end
      issue     = (state_ff == bpfa_pkg::ST_WORK) && (rd_cnt_ff <= WCW'(last_w))
               && !work_done;
      slot_free = !rsp_tvalid_ff || rsp_tready;
   end

   // Word unit control: span limits on the first and last word of the pass
   always_comb begin
      wctl.op     = op_ff;
      wctl.lo_bit = (rd_idx_ff == first_w) ? first_ff[4:0] : 5'd0;
      wctl.hi_bit = (rd_idx_ff == last_w) ? lastm1_ff[4:0] : 5'd31;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpfa_pkg::ST_INIT: begin
            if (rd_cnt_ff == LAST_WORD) state_in = bpfa_pkg::ST_IDLE;
         end
         bpfa_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = bpfa_pkg::ST_PREP;
         end
         bpfa_pkg::ST_PREP: begin
            case (kind_ff)
               bpfa_pkg::KIND_ALLOC:     state_in = bpfa_pkg::ST_WORK;
               bpfa_pkg::KIND_FREE_PAGE: state_in = free_bad ? bpfa_pkg::ST_RESP
                                                             : bpfa_pkg::ST_WORK;
               default:                  state_in = range_empty ? bpfa_pkg::ST_RESP
                                                                : bpfa_pkg::ST_WORK;
            endcase
         end
         bpfa_pkg::ST_WORK: begin
            if (work_done) state_in = bpfa_pkg::ST_RESP;
         end
         bpfa_pkg::ST_RESP: begin
            if (slot_free) state_in = bpfa_pkg::ST_IDLE;
         end
         default: state_in = bpfa_pkg::ST_INIT;
      endcase
   end

   // Datapath, memory port and response register controls
   always_comb begin
      kind_in       = kind_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      sum_in        = sum_ff;
      first_in      = first_ff;
      lastm1_in     = lastm1_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = WAW'(rd_cnt_ff);
      mem_wr_en     = 1'b0;
      mem_wr_addr   = rd_idx_ff;
      mem_wr_data   = wres.new_word;

      case (state_ff)
         // clearing pass: every word to all ones
         bpfa_pkg::ST_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = WAW'(rd_cnt_ff);
            mem_wr_data = '1;
            rd_cnt_in   = rd_cnt_ff + WCW'(1);
         end
         // capture the request beat
         bpfa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = bpfa_pkg::kind_type'(req_tuser[1:0]);
               addr_in = req_tdata[31:0];
               sum_in  = {1'b0, req_tdata[31:0]} + {1'b0, req_tdata[63:32]};
            end
         end
         // frame span and early results
         bpfa_pkg::ST_PREP: begin
            res_addr_in   = '1;
            res_status_in = bpfa_pkg::STATUS_DONE;
            case (kind_ff)
               bpfa_pkg::KIND_ALLOC: begin
                  op_in     = bpfa_pkg::WOP_SCAN;
                  first_in  = '0;
                  lastm1_in = LAST_FRM;
               end
               bpfa_pkg::KIND_FREE_PAGE: begin
                  op_in     = bpfa_pkg::WOP_CLEAR;
                  first_in  = FW'(start_frm);
                  lastm1_in = FW'(start_frm);
                  if (free_bad) res_status_in = bpfa_pkg::STATUS_REJECTED;
               end
               bpfa_pkg::KIND_FREE_RANGE: begin
                  op_in     = bpfa_pkg::WOP_CLEAR;
                  first_in  = FW'(start_frm);
                  lastm1_in = FW'(last_clip - EW'(1));
               end
               default: begin
                  op_in     = bpfa_pkg::WOP_SET;
                  first_in  = FW'(start_frm);
                  lastm1_in = FW'(last_clip - EW'(1));
               end
            endcase
            rd_cnt_in = WCW'(first_in >> 5);
         end
         // streaming read-modify-write over the span
         bpfa_pkg::ST_WORK: begin
            mem_rd_en = issue;
            rd_vld_in = issue;
            rd_idx_in = WAW'(rd_cnt_ff);
            if (issue) rd_cnt_in = rd_cnt_ff + WCW'(1);
            if (op_ff == bpfa_pkg::WOP_SCAN) begin
               mem_wr_en = scan_hit;
               if (scan_hit) begin
                  res_addr_in   = 32'(scan_frame) << SH;
                  res_status_in = bpfa_pkg::STATUS_DONE;
               end else if (scan_fail) begin
                  res_addr_in   = '1;
                  res_status_in = bpfa_pkg::STATUS_NO_FRAME;
               end
            end else begin
               mem_wr_en = rd_vld_ff;
            end
         end
         // post the result beat
         bpfa_pkg::ST_RESP: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = res_addr_ff;
               rsp_tuser_in  = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Bitmap memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) mem[mem_wr_addr] <= mem_wr_data;
      if (mem_rd_en) mem_rdata_ff <= mem[mem_rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bpfa_pkg::ST_INIT;
         rd_cnt_ff     <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_cnt_ff     <= rd_cnt_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      sum_ff        <= sum_in;
      first_ff      <= first_in;
      lastm1_ff     <= lastm1_in;
      rd_idx_ff     <= rd_idx_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign req_tready = (state_ff == bpfa_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Claiming a frame sets exactly one more bit in the scanned word
   a_claim_one_bit: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && state_ff == bpfa_pkg::ST_WORK && op_ff == bpfa_pkg::WOP_SCAN)
      |-> ($countones(mem_wr_data) == $countones(mem_rdata_ff) + 1))
      else $error("allocation write did not claim exactly one frame");

   // Any beat with a status other than done carries all ones
   a_fail_addr_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != bpfa_pkg::STATUS_DONE) |-> (rsp_tdata == '1))
      else $error("failure beat without all-ones address");

   // A taken request makes the block busy on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a request was in flight");

   // Pipelined reads exist only inside a word pass
   a_read_in_pass: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == bpfa_pkg::ST_WORK))
      else $error("word read pending outside a word pass");

endmodule
